// ----- design/ffa_pkg.sv -----
// Shared types and constants for the first-fit block allocator.
`default_nettype none
package ffa_pkg;
   localparam int MAX_BLOCKS   = 64;
   localparam int HEAP_BYTES   = 65536;
   localparam int HEADER_BYTES = 16;
   localparam int IDX_W        = $clog2(MAX_BLOCKS);
   localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
   localparam int TOP_W        = $clog2(HEAP_BYTES + 1);
   localparam int ADDR_W       = 16;
   localparam int LIMIT_W      = 17;

   typedef enum logic [1:0] {
      KIND_ALLOC   = 2'd0,
      KIND_CALLOC  = 2'd1,
      KIND_RESIZE  = 2'd2,
      KIND_RELEASE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_REFUSED = 2'd1,
      ST_UNKNOWN = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_LAUNCH, S_SCAN, S_ALLOC, S_REL
   } state_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] request_size;
      logic [ADDR_W-1:0] item_count;
      logic [ADDR_W-1:0] block_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] result_address;
      logic [1:0]        status;
   } rsp_type;

   // search beat that walks the cell chain
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] size;
      logic [ADDR_W-1:0] addr;
      logic              hit_found;
      logic [IDX_W-1:0]  hit_idx;
      logic [ADDR_W-1:0] hit_size;
      logic              fit_found;
      logic [IDX_W-1:0]  fit_idx;
      logic [ADDR_W-1:0] fit_addr;
   } token_type;

   // broadcast write into one cell
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  idx;
      logic              full;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] size;
      logic              free;
   } wr_type;
endpackage
`default_nettype wire

// ----- design/ffa_cell.sv -----
// One table entry of the allocator with its stage of the search chain.
`default_nettype none
module ffa_cell (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [ffa_pkg::IDX_W-1:0] cell_index,
   input  wire logic [ffa_pkg::CNT_W-1:0] block_count,
   input  wire ffa_pkg::wr_type          wr,
   input  wire ffa_pkg::token_type       tok_i,
   output      ffa_pkg::token_type       tok_o
);
   import ffa_pkg::*;

   logic [ADDR_W-1:0] addr_ff, size_ff;
   logic              free_ff;
   token_type         tok_ff, tok_in;
   logic              live, hit, fit;

   // entry storage
   always_ff @(posedge clock) begin
      if (wr.en && wr.idx == cell_index) begin
         if (wr.full) begin
            addr_ff <= wr.addr;
            size_ff <= wr.size;
         end
         free_ff <= wr.free;
      end
   end

   // compare against the passing beat
   always_comb begin
      live   = {1'b0, cell_index} < block_count;
      hit    = live && addr_ff == tok_i.addr;
      fit    = live && free_ff && size_ff >= tok_i.size;
      tok_in = tok_i;
      if (!tok_i.hit_found && hit) begin
         tok_in.hit_found = 1'b1;
         tok_in.hit_idx   = cell_index;
         tok_in.hit_size  = size_ff;
      end
      if (!tok_i.fit_found && fit) begin
         tok_in.fit_found = 1'b1;
         tok_in.fit_idx   = cell_index;
         tok_in.fit_addr  = addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;
endmodule
`default_nettype wire

// ----- design/first_fit_block_allocator_unit.sv -----
// Top level of the first-fit block allocator: request sequencer and cell chain.
`default_nettype none
// Takes one request at a time while busy is low and returns one result, shown
// for a single cycle with rsp_valid; the receiver cannot stall it. After S_MUL
// and S_LAUNCH the search beat passes one table cell per cycle down the chain,
// then S_ALLOC updates the table, followed by S_REL to free the old block for a
// resize that moves it. The heap limit is written via csr_we.
module first_fit_block_allocator_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output      logic                       busy,
   input  wire ffa_pkg::req_type           req_data,
   output      logic                       rsp_valid,
   output      ffa_pkg::rsp_type           rsp_data,
   input  wire logic                       csr_we,
   input  wire logic [ffa_pkg::LIMIT_W-1:0] csr_wdata
);
   import ffa_pkg::*;

   state_type          state_ff, state_in;
   req_type            req_ff;
   logic [2*ADDR_W-1:0] prod_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TOP_W-1:0]   top_ff, top_in;
   token_type          res_ff;
   rsp_type            rsp_ff, rsp_in, held_ff, held_in;
   logic               rsp_valid_ff, rsp_valid_in;
   wr_type             wr;
   token_type          tok [MAX_BLOCKS+1];
   token_type          launch;

   logic [ADDR_W-1:0]  eff_size;
   logic               calloc_bad, do_alloc, do_rel, alloc_ok, rel_after, rel_top;
   logic [TOP_W:0]     new_top, limit;
   logic [TOP_W:0]     hit_end;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_W'(65536);
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   // cell chain
   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      ffa_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_index  (IDX_W'(i)),
         .block_count (count_ff),
         .wr          (wr),
         .tok_i       (tok[i]),
         .tok_o       (tok[i+1])
      );
   end

   assign eff_size   = (req_ff.kind == KIND_CALLOC) ? prod_ff[ADDR_W-1:0] : req_ff.request_size;
   assign calloc_bad = req_ff.item_count == '0 || req_ff.request_size == '0 ||
                       prod_ff[2*ADDR_W-1:ADDR_W] != '0;
   assign limit      = ({1'b0, TOP_W'(limit_ff)} > (TOP_W+1)'(HEAP_BYTES)) ?
                       (TOP_W+1)'(HEAP_BYTES) : (TOP_W+1)'(limit_ff);
   assign new_top    = {1'b0, top_ff} + (TOP_W+1)'(HEADER_BYTES) + (TOP_W+1)'(eff_size);
   assign hit_end    = (TOP_W+1)'(req_ff.block_address) + (TOP_W+1)'(res_ff.hit_size);
   assign rel_top    = ({1'b0, res_ff.hit_idx} + CNT_W'(1)) == count_ff &&
                       hit_end == {1'b0, top_ff};

   always_comb begin
      launch           = '0;
      launch.valid     = state_ff == S_LAUNCH;
      launch.size      = eff_size;
      launch.addr      = req_ff.block_address;
   end

   assign tok[0] = launch;

   // state and table registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) req_ff <= req_data;
      if (state_ff == S_MUL) prod_ff <= req_ff.item_count * req_ff.request_size;
      if (tok[MAX_BLOCKS].valid) res_ff <= tok[MAX_BLOCKS];
      rsp_ff  <= rsp_in;
      held_ff <= held_in;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      held_in      = held_ff;
      wr           = '0;
      do_alloc     = 1'b0;
      do_rel       = 1'b0;
      rel_after    = 1'b0;
      alloc_ok     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_MUL;
         end
         S_MUL:    state_in = S_LAUNCH;
         S_LAUNCH: state_in = S_SCAN;
         S_SCAN: begin
            if (tok[MAX_BLOCKS].valid) state_in = S_ALLOC;
         end
         S_ALLOC: begin
            rsp_in.result_address = '0;
            rsp_in.status         = ST_DONE;
            case (req_ff.kind)
               KIND_ALLOC: do_alloc = 1'b1;
               KIND_CALLOC: begin
                  if (calloc_bad) rsp_in.status = ST_REFUSED;
                  else do_alloc = 1'b1;
               end
               KIND_RESIZE: begin
                  if (req_ff.block_address == '0 || req_ff.request_size == '0) begin
                     do_alloc = 1'b1;
                  end else if (!res_ff.hit_found) begin
                     rsp_in.status = ST_UNKNOWN;
                  end else if (res_ff.hit_size >= eff_size) begin
                     rsp_in.result_address = req_ff.block_address;
                  end else begin
                     do_alloc  = 1'b1;
                     rel_after = 1'b1;
                  end
               end
               KIND_RELEASE: begin
                  if (req_ff.block_address != '0) begin
                     if (!res_ff.hit_found) rsp_in.status = ST_UNKNOWN;
                     else do_rel = 1'b1;
                  end
               end
               default: ;
            endcase
            // first fit, else append at the heap top
            if (do_alloc) begin
               if (eff_size == '0) begin
                  alloc_ok = 1'b0;
               end else if (res_ff.fit_found) begin
                  alloc_ok              = 1'b1;
                  wr.en                 = 1'b1;
                  wr.idx                = res_ff.fit_idx;
                  wr.free               = 1'b0;
                  rsp_in.result_address = res_ff.fit_addr;
               end else if (count_ff < CNT_W'(MAX_BLOCKS) && new_top <= limit) begin
                  alloc_ok              = 1'b1;
                  wr.en                 = 1'b1;
                  wr.idx                = count_ff[IDX_W-1:0];
                  wr.full               = 1'b1;
                  wr.addr               = ADDR_W'(top_ff + TOP_W'(HEADER_BYTES));
                  wr.size               = eff_size;
                  wr.free               = 1'b0;
                  rsp_in.result_address = wr.addr;
                  count_in              = count_ff + CNT_W'(1);
                  top_in                = new_top[TOP_W-1:0];
               end
               if (!alloc_ok) begin
                  rsp_in.status         = ST_REFUSED;
                  rsp_in.result_address = '0;
               end
            end
            if (rel_after && alloc_ok) begin
               held_in  = rsp_in;
               state_in = S_REL;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_REL: begin
            do_rel       = 1'b1;
            rsp_in       = held_ff;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // release: shrink if top block, else mark free
      if (do_rel) begin
         if (rel_top) begin
            top_in   = TOP_W'(req_ff.block_address) - TOP_W'(HEADER_BYTES);
            count_in = count_ff - CNT_W'(1);
         end else begin
            wr.en   = 1'b1;
            wr.idx  = res_ff.hit_idx;
            wr.free = 1'b1;
         end
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_IDLE) else $error("result shown while busy");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted beat did not raise busy");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BLOCKS)) else $error("block count overflow");
   a_top_max: assert property (@(posedge clock) disable iff (reset)
      top_ff <= TOP_W'(HEAP_BYTES)) else $error("heap top beyond heap");
endmodule
`default_nettype wire

// ----- tb/sv/first_fit_block_allocator_unit_test.sv -----
// Testbench for the first-fit block allocator: directed and random requests checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module first_fit_block_allocator_unit_test;
   import ffa_pkg::*;

   localparam int WATCHDOG_CYCLES = 4000;
   localparam int SETTLE_CYCLES   = 80;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   req_type             req_data = '0;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_we = 1'b0;
   logic [LIMIT_W-1:0]  csr_wdata = '0;

   first_fit_block_allocator_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // predicted allocator state
   int blk_addr [MAX_BLOCKS];
   int blk_size [MAX_BLOCKS];
   bit blk_free [MAX_BLOCKS];
   int blk_count = 0;
   int heap_top = 0;
   int heap_limit = 65536;

   req_type pending_q [$];
   rsp_type result_q [$];
   int      sender_idle_pct = 28;
   int      mismatches = 0;
   int      stall_cycles = 0;

   function automatic int lookup_block(int addr);
      for (int i = 0; i < blk_count; i++)
         if (blk_addr[i] == addr) return i;
      return -1;
   endfunction

   // first fit over the table, else append at the heap top; 0 when refused
   function automatic int grab_block(int size);
      int lim;
      if (size == 0) return 0;
      for (int i = 0; i < blk_count; i++)
         if (blk_free[i] && blk_size[i] >= size) begin
            blk_free[i] = 1'b0;
            return blk_addr[i];
         end
      if (blk_count >= MAX_BLOCKS) return 0;
      lim = (heap_limit > HEAP_BYTES) ? HEAP_BYTES : heap_limit;
      if (heap_top + HEADER_BYTES + size > lim) return 0;
      blk_addr[blk_count] = heap_top + HEADER_BYTES;
      blk_size[blk_count] = size;
      blk_free[blk_count] = 1'b0;
      blk_count++;
      heap_top = heap_top + HEADER_BYTES + size;
      return heap_top - size;
   endfunction

   function automatic void drop_block(int idx);
      if (idx + 1 == blk_count && blk_addr[idx] + blk_size[idx] == heap_top) begin
         heap_top = blk_addr[idx] - HEADER_BYTES;
         blk_count--;
      end else
         blk_free[idx] = 1'b1;
   endfunction

   function automatic rsp_type serve_request(req_type r);
      rsp_type o;
      int      size, cnt, addr, idx, res;
      longint  prod;
      size = r.request_size;
      cnt  = r.item_count;
      addr = r.block_address;
      res  = 0;
      o.status = ST_DONE;
      case (kind_type'(r.kind))
         KIND_ALLOC: begin
            res = grab_block(size);
            if (res == 0) o.status = ST_REFUSED;
         end
         KIND_CALLOC: begin
            // full 32-bit product of two 16-bit fields
            prod = longint'(cnt) * longint'(size);
            if (cnt == 0 || size == 0 || prod > 65535) o.status = ST_REFUSED;
            else begin
               res = grab_block(int'(prod));
               if (res == 0) o.status = ST_REFUSED;
            end
         end
         KIND_RESIZE: begin
            if (addr == 0 || size == 0) begin
               res = grab_block(size);
               if (res == 0) o.status = ST_REFUSED;
            end else begin
               idx = lookup_block(addr);
               if (idx < 0) o.status = ST_UNKNOWN;
               else if (blk_size[idx] >= size) res = addr;
               else begin
                  res = grab_block(size);
                  if (res == 0) o.status = ST_REFUSED;
                  else begin
                     idx = lookup_block(addr);
                     if (idx >= 0) drop_block(idx);
                  end
               end
            end
         end
         default: begin
            if (addr != 0) begin
               idx = lookup_block(addr);
               if (idx < 0) o.status = ST_UNKNOWN;
               else drop_block(idx);
            end
         end
      endcase
      o.result_address = res[ADDR_W-1:0];
      return o;
   endfunction

   // driver: one beat per accepted request, expectation logged at acceptance
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            result_q.push_back(serve_request(req_data));
         end
         if (!start || !busy) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_data <= pending_q.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: results are strobed for one cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (result_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: addr %0d status %0d",
                        rsp_data.result_address, rsp_data.status);
         end else begin
            rsp_type want;
            want = result_q.pop_front();
            if (want.result_address !== rsp_data.result_address ||
                want.status !== rsp_data.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected addr %0d status %0d, got addr %0d status %0d",
                           want.result_address, want.status,
                           rsp_data.result_address, rsp_data.status);
            end
         end
      end
   end

   // watchdog on cycles with no traffic
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic req_type make_req(kind_type k, int size, int cnt, int addr);
      req_type r;
      r.kind          = k;
      r.request_size  = size[ADDR_W-1:0];
      r.item_count    = cnt[ADDR_W-1:0];
      r.block_address = addr[ADDR_W-1:0];
      return r;
   endfunction

   task automatic wait_drained();
      while (pending_q.size() != 0 || start || result_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_limit(int value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value[LIMIT_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      heap_limit = value;
   endtask

   // random requests in short batches, addresses mostly drawn from the current table
   task automatic random_batches(int total);
      int      k, size, cnt, addr, sel;
      kind_type op;
      while (total > 0) begin
         wait_drained();
         for (int n = 0; n < 8 && total > 0; n++, total--) begin
            k = $urandom_range(99);
            op = (k < 35) ? KIND_ALLOC : (k < 45) ? KIND_CALLOC :
                 (k < 65) ? KIND_RESIZE : KIND_RELEASE;
            sel = $urandom_range(99);
            size = (sel < 5) ? $urandom_range(65535) : (sel < 9) ? 0 :
                   (sel < 15) ? $urandom_range(2048) : $urandom_range(1, 96);
            cnt = $urandom_range(0, 12);
            if (op == KIND_CALLOC) begin
               if (sel < 10) cnt = $urandom_range(65535);
               else if (size > 16) size = $urandom_range(1, 16);
            end else if ($urandom_range(9) == 0)
               cnt = $urandom_range(65535);
            sel = $urandom_range(99);
            if (sel < 80 && blk_count > 0)
               addr = blk_addr[$urandom_range(blk_count - 1)];
            else if (sel < 90)
               addr = 0;
            else
               addr = $urandom_range(65535);
            pending_q.push_back(make_req(op, size, cnt, addr));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_limit(65536);

      // directed: size extremes, every kind, reuse, null and unknown addresses
      pending_q.push_back(make_req(KIND_ALLOC,   0,     0, 0));
      pending_q.push_back(make_req(KIND_ALLOC,   65535, 65535, 65535));
      pending_q.push_back(make_req(KIND_ALLOC,   1,     0, 0));
      pending_q.push_back(make_req(KIND_CALLOC,  5,     3, 0));
      pending_q.push_back(make_req(KIND_CALLOC,  7,     0, 0));
      pending_q.push_back(make_req(KIND_CALLOC,  256,   256, 0));
      pending_q.push_back(make_req(KIND_CALLOC,  65535, 65535, 0));
      pending_q.push_back(make_req(KIND_CALLOC,  0,     4, 0));
      pending_q.push_back(make_req(KIND_RESIZE,  10,    0, 0));
      pending_q.push_back(make_req(KIND_RESIZE,  0,     0, 16));
      pending_q.push_back(make_req(KIND_RESIZE,  1,     0, 16));
      pending_q.push_back(make_req(KIND_RESIZE,  40,    0, 16));
      pending_q.push_back(make_req(KIND_ALLOC,   1,     0, 0));
      pending_q.push_back(make_req(KIND_RELEASE, 0,     0, 0));
      pending_q.push_back(make_req(KIND_RELEASE, 0,     0, 65535));
      pending_q.push_back(make_req(KIND_RESIZE,  5,     0, 65535));
      pending_q.push_back(make_req(KIND_RELEASE, 0,     0, 90));
      pending_q.push_back(make_req(KIND_RELEASE, 0,     0, 33));
      pending_q.push_back(make_req(KIND_RELEASE, 0,     0, 33));
      pending_q.push_back(make_req(KIND_ALLOC,   20,    0, 0));
      pending_q.push_back(make_req(KIND_RESIZE,  65535, 0, 64));
      pending_q.push_back(make_req(KIND_ALLOC,   65535, 0, 0));

      // fill the table with tiny blocks until it refuses
      for (int i = 0; i < MAX_BLOCKS + 2; i++)
         pending_q.push_back(make_req(KIND_ALLOC, 1, 0, 0));
      random_batches(180);

      // zero limit: new blocks can only come from reuse of free blocks
      write_limit(0);
      random_batches(60);

      // largest register value, sender idles more often
      write_limit(131071);
      sender_idle_pct = 48;
      random_batches(120);

      // tight limit, no idling
      write_limit(1500);
      sender_idle_pct = 0;
      random_batches(160);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && result_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
`default_nettype wire
